// ----- rtl/sm3_pkg.sv -----
// sm3_pkg: shared types, constants and functions of the sm3 hash engine
// no dependencies
`timescale 1ns / 1ps
package sm3_pkg;

  localparam logic [31:0] IV0 = 32'h7380166F;
  localparam logic [31:0] IV1 = 32'h4914B2B9;
  localparam logic [31:0] IV2 = 32'h172442D7;
  localparam logic [31:0] IV3 = 32'hDA8A0600;
  localparam logic [31:0] IV4 = 32'hA96F30BC;
  localparam logic [31:0] IV5 = 32'h163138AA;
  localparam logic [31:0] IV6 = 32'hE38DEE4D;
  localparam logic [31:0] IV7 = 32'hB0FB0E4E;
  localparam logic [31:0] TJ_LO = 32'h79CC4519;
  localparam logic [31:0] TJ_HI = 32'h7A879D8A;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // word passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RUN,
    ST_EMIT
  } core_state_e;

  function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
  endfunction

endpackage

// ----- rtl/sm3_front.sv -----
// sm3_front: input queue between the byte channel and the compression core
// depends on sm3_pkg
`timescale 1ns / 1ps
module sm3_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  sm3_pkg::item_t item_i,
  output logic           avail_o,
  input  logic           take_i,
  output sm3_pkg::item_t item_o
);
  sm3_pkg::item_t mem_q [4];
  logic [2:0] wr_q, rd_q;
  logic [2:0] wr_d, rd_d;

  assign full_o  = (wr_q - rd_q) == 3'd4;
  assign avail_o = wr_q != rd_q;
  assign item_o  = mem_q[rd_q[1:0]];

  // pointer update
  always_comb begin
    wr_d = wr_q + {2'b0, push_i && !full_o};
    rd_d = rd_q + {2'b0, take_i && avail_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q[1:0]] <= item_i;
    end
  end
endmodule

// ----- rtl/sm3_core.sv -----
// sm3_core: block gathering, padding, 64-round compression and digest output
// depends on sm3_pkg
`timescale 1ns / 1ps
module sm3_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  output logic           take_o,
  input  sm3_pkg::item_t item_i,
  output logic           empty_o,
  input  logic           pop_i,
  output logic [31:0]    digest_word_o,
  output logic [2:0]     word_index_o,
  output logic           digest_done_o
);
  sm3_pkg::core_state_e state_q, state_d;
  logic [31:0] cv_q [8];
  logic [31:0] wk_q [8];          // a..h
  logic [31:0] win_q [16];        // sliding message window
  logic [5:0]  fill_q;
  logic [63:0] bits_q;
  logic [63:0] total_q;
  logic [5:0]  round_q;
  logic        final_q;           // this block ends the message
  logic        second_q;          // padding needs one more block
  logic        mark_q;            // pad byte still to be written at fill_q
  logic [2:0]  oidx_q;
  logic [31:0] wnew, wx;
  logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
  logic [7:0]  pad_b;
  logic [5:0]  pad_i;

  assign empty_o       = state_q != sm3_pkg::ST_EMIT;
  assign digest_word_o = cv_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign digest_done_o = oidx_q == 3'd7;
  assign take_o        = state_q == sm3_pkg::ST_IDLE && avail_i;

  // round datapath
  always_comb begin
    wnew = sm3_pkg::p1(win_q[0] ^ win_q[7] ^ sm3_pkg::rol(win_q[13], 5'd15)) ^
           sm3_pkg::rol(win_q[3], 5'd7) ^ win_q[10];
    wx   = win_q[0] ^ win_q[4];
    tj   = (round_q < 6'd16) ? sm3_pkg::TJ_LO : sm3_pkg::TJ_HI;
    a12  = sm3_pkg::rol(wk_q[0], 5'd12);
    ss1  = sm3_pkg::rol(a12 + wk_q[4] + sm3_pkg::rol(tj, round_q[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    if (round_q < 6'd16) begin
      ffv = wk_q[0] ^ wk_q[1] ^ wk_q[2];
      ggv = wk_q[4] ^ wk_q[5] ^ wk_q[6];
    end else begin
      ffv = (wk_q[0] & wk_q[1]) | (wk_q[0] & wk_q[2]) | (wk_q[1] & wk_q[2]);
      ggv = (wk_q[4] & wk_q[5]) | (~wk_q[4] & wk_q[6]);
    end
    tt1 = ffv + wk_q[3] + ss2 + wx;
    tt2 = ggv + wk_q[7] + ss1 + win_q[0];
  end

  // padding byte for the position being filled
  always_comb begin
    pad_i = fill_q;
    if (mark_q) begin
      pad_b = sm3_pkg::PAD_BYTE;
    end else if (fill_q >= sm3_pkg::LEN_OFFSET && !second_q) begin
      pad_b = total_q[8'd63 - {2'b0, fill_q[2:0], 3'b0} -: 8];
    end else begin
      pad_b = 8'h00;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sm3_pkg::ST_IDLE: if (avail_i) begin
        if (item_i.has_byte && fill_q == 6'd63) state_d = sm3_pkg::ST_RUN;
        else if (item_i.is_last) state_d = sm3_pkg::ST_PAD;
      end
      sm3_pkg::ST_PAD: if (fill_q == 6'd63) state_d = sm3_pkg::ST_RUN;
      sm3_pkg::ST_RUN: if (round_q == 6'd63) begin
        if (!final_q) state_d = sm3_pkg::ST_IDLE;
        else if (second_q) state_d = sm3_pkg::ST_PAD;
        else state_d = sm3_pkg::ST_EMIT;
      end
      sm3_pkg::ST_EMIT: if (pop_i && oidx_q == 3'd7) state_d = sm3_pkg::ST_IDLE;
      default: state_d = sm3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sm3_pkg::ST_IDLE;
      fill_q   <= '0;
      bits_q   <= '0;
      round_q  <= '0;
      final_q  <= 1'b0;
      second_q <= 1'b0;
      mark_q   <= 1'b0;
      oidx_q   <= '0;
      cv_q     <= '{sm3_pkg::IV0, sm3_pkg::IV1, sm3_pkg::IV2, sm3_pkg::IV3,
                    sm3_pkg::IV4, sm3_pkg::IV5, sm3_pkg::IV6, sm3_pkg::IV7};
    end else begin
      state_q <= state_d;
      case (state_q)
        // take one word from the queue
        sm3_pkg::ST_IDLE: if (avail_i) begin
          if (item_i.has_byte) begin
            fill_q <= fill_q + 6'd1;
            if (fill_q == 6'd63) begin
              round_q  <= '0;
              final_q  <= item_i.is_last;
              bits_q   <= bits_q + 64'd512;
              // padding then starts a fresh block
              second_q <= item_i.is_last;
              mark_q   <= item_i.is_last;
            end else if (item_i.is_last) begin
              final_q  <= 1'b1;
              second_q <= (fill_q + 6'd1) >= 6'd56;
              mark_q   <= 1'b1;
            end
          end else if (item_i.is_last) begin
            final_q  <= 1'b1;
            second_q <= fill_q >= 6'd56;
            mark_q   <= 1'b1;
          end
        end
        // one pad byte per cycle
        sm3_pkg::ST_PAD: begin
          fill_q <= fill_q + 6'd1;
          mark_q <= 1'b0;
          if (fill_q == 6'd63) round_q <= '0;
        end
        // one round per cycle
        sm3_pkg::ST_RUN: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            for (int k = 0; k < 8; k++) begin
              cv_q[k] <= cv_q[k] ^ ((k == 0) ? tt1 : (k == 1) ? wk_q[0] :
                         (k == 2) ? sm3_pkg::rol(wk_q[1], 5'd9) : (k == 3) ? wk_q[2] :
                         (k == 4) ? sm3_pkg::p0(tt2) : (k == 5) ? wk_q[4] :
                         (k == 6) ? sm3_pkg::rol(wk_q[5], 5'd19) : wk_q[6]);
            end
            if (second_q) second_q <= 1'b0;
          end
        end
        sm3_pkg::ST_EMIT: if (pop_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cv_q    <= '{sm3_pkg::IV0, sm3_pkg::IV1, sm3_pkg::IV2, sm3_pkg::IV3,
                         sm3_pkg::IV4, sm3_pkg::IV5, sm3_pkg::IV6, sm3_pkg::IV7};
            bits_q  <= '0;
            fill_q  <= '0;
            final_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // message window, working variables and length
  always_ff @(posedge clk_i) begin
    case (state_q)
      sm3_pkg::ST_IDLE: if (avail_i) begin
        total_q <= bits_q + {55'd0, fill_q, 3'd0} + {60'd0, item_i.has_byte, 3'd0};
        if (item_i.has_byte) begin
          win_q[fill_q[5:2]][8'd31 - {3'b0, fill_q[1:0], 3'b0} -: 8] <= item_i.data;
          if (fill_q == 6'd63) wk_q <= cv_q;
        end
      end
      sm3_pkg::ST_PAD: begin
        win_q[pad_i[5:2]][8'd31 - {3'b0, pad_i[1:0], 3'b0} -: 8] <= pad_b;
        if (fill_q == 6'd63) wk_q <= cv_q;
      end
      sm3_pkg::ST_RUN: begin
        for (int k = 0; k < 15; k++) win_q[k] <= win_q[k + 1];
        win_q[15] <= wnew;
        wk_q <= '{tt1, wk_q[0], sm3_pkg::rol(wk_q[1], 5'd9), wk_q[2],
                  sm3_pkg::p0(tt2), wk_q[4], sm3_pkg::rol(wk_q[5], 5'd19), wk_q[6]};
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/sm3_hash_engine_top.sv -----
// sm3_hash_engine_top: sm3 digest engine, byte queue in front of the core
// depends on sm3_pkg, sm3_front, sm3_core
//
// Usage: push one word per message byte (msg_byte_i, has_byte_i, is_last_i)
// while full is low. A word with is_last_i high ends the message; the engine
// pads it and later offers eight digest words, index 0 first, on the result
// side while empty is low; pop takes one. digest_done_o marks word 7.
// Bytes enter the core one at a time until a 64-byte block is full; the block
// is then compressed by the single shared round unit while no input is taken.
// After the last word, padding writes one byte a cycle up to the block end and
// 64 rounds follow; when the length does not fit, a second padded block and its
// 64 rounds come before the digest. A four-word queue decouples
// the input from the core. While results wait, the core holds and the queue
// fills; input stalls once it is full. Reset returns the chaining value to
// the initial value, clears counts and empties the queue.
`timescale 1ns / 1ps
module sm3_hash_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        digest_done_o
);
  sm3_pkg::item_t in_item, q_item;
  logic q_avail, q_take;

  assign in_item = '{data: msg_byte_i, has_byte: has_byte_i, is_last: is_last_i};

  sm3_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .avail_o(q_avail), .take_i(q_take), .item_o(q_item)
  );

  sm3_core u_core (
    .clk_i, .rst_ni, .avail_i(q_avail), .take_o(q_take), .item_i(q_item),
    .empty_o(empty), .pop_i(pop), .digest_word_o, .word_index_o, .digest_done_o
  );
endmodule
